// ===== hdl/tree_level_ancestor_lca_unit_assert.svh =====
// ----------------------------------------------------------------------------
// tree level ancestor / lca unit assertion macros
// shared property forms for the unit's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TREE_LEVEL_ANCESTOR_LCA_UNIT_ASSERT_SVH
`define TREE_LEVEL_ANCESTOR_LCA_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define TLAL_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// consequence in the cycle after the condition
`define TLAL_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/tlal_pkg.sv =====
// ----------------------------------------------------------------------------
// tlal_pkg
// field widths, opcodes and controller/datapath interface types
// ----------------------------------------------------------------------------
package tlal_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int STEPS_W = 10;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_LA  = 2'd1,
    OP_LCA = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  // datapath register actions
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_ACCEPT,
    DP_CLEAR,
    DP_LA_LOAD,
    DP_LCA_V,
    DP_LCA_U,
    DP_TAKE_CUR,
    DP_TAKE_OTH,
    DP_ADD_P,
    DP_ADD_J,
    DP_ADD_WR,
    DP_OUT
  } dp_op_t;

  // table read address source
  typedef enum logic [2:0] {
    RD_A,
    RD_B,
    RD_DATA_JUMP,
    RD_CUR_JUMP,
    RD_CUR_PARENT,
    RD_OTH_JUMP,
    RD_OTH_PARENT
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    a_ok;
    logic    b_ok;
    logic    a_zero;
    logic    b_zero;
    logic    rd_depth_zero;
    logic    climb_more;
    logic    jump_ok;
    logic    same_node;
    logic    jumps_differ;
    logic    clr_last;
  } dp_status_t;

endpackage

// ===== hdl/tlal_dpath.sv =====
// ----------------------------------------------------------------------------
// tlal_dpath
// tree tables (parent, depth, jump) in one memory, climb registers and result
// ----------------------------------------------------------------------------
module tlal_dpath #(
  parameter int MAX_NODES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tlal_pkg::dp_cmd_t                 cmd,
  output tlal_pkg::dp_status_t              status,
  input  logic [tlal_pkg::OP_W-1:0]         in_opcode,
  input  logic [tlal_pkg::NODE_W-1:0]       in_node_a,
  input  logic [tlal_pkg::NODE_W-1:0]       in_node_b,
  input  logic [tlal_pkg::STEPS_W-1:0]      in_steps,
  output logic [tlal_pkg::NODE_W-1:0]       result_node
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef struct packed {
    logic [AW-1:0]                parent;
    logic [tlal_pkg::DEPTH_W-1:0] depth;
    logic [AW-1:0]                jump;
  } entry_t;

  entry_t mem [MAX_NODES];
  entry_t rd_data;
  entry_t wr_data;
  entry_t new_entry;
  entry_t cur_e;
  entry_t oth_e;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_q;
  logic [AW-1:0] wr_addr;
  logic          we;
  logic [AW-1:0] clr_cnt;

  tlal_pkg::opcode_t              opcode;
  logic [tlal_pkg::NODE_W-1:0]    node_a;
  logic [tlal_pkg::NODE_W-1:0]    node_b;
  logic [tlal_pkg::STEPS_W-1:0]   steps;
  logic [AW-1:0]                  a_addr;
  logic [AW-1:0]                  b_addr;
  logic [AW-1:0]                  cur_v;
  logic [AW-1:0]                  oth_v;
  logic [tlal_pkg::DEPTH_W-1:0]   target;
  logic [tlal_pkg::DEPTH_W:0]     span_low;
  logic [tlal_pkg::DEPTH_W:0]     span_high;

  // out-of-range node reads as the root
  function automatic logic [AW-1:0] clip_node(input logic [tlal_pkg::NODE_W-1:0] n);
    logic [AW-1:0] r;
    if (32'(n) < 32'(MAX_NODES)) begin
      r = AW'(n);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign a_addr = clip_node(node_a);
  assign b_addr = clip_node(node_b);

  always_comb begin
    unique case (cmd.rd_sel)
      tlal_pkg::RD_A:          rd_addr = a_addr;
      tlal_pkg::RD_B:          rd_addr = b_addr;
      tlal_pkg::RD_DATA_JUMP:  rd_addr = rd_data.jump;
      tlal_pkg::RD_CUR_JUMP:   rd_addr = cur_e.jump;
      tlal_pkg::RD_CUR_PARENT: rd_addr = cur_e.parent;
      tlal_pkg::RD_OTH_JUMP:   rd_addr = oth_e.jump;
      tlal_pkg::RD_OTH_PARENT: rd_addr = oth_e.parent;
      default:                 rd_addr = a_addr;
    endcase
  end

  // new leaf: parent in cur_e, jp in oth_e, jjp entry on the read port
  always_comb begin
    span_low  = {1'b0, cur_e.depth} - {1'b0, oth_e.depth};
    span_high = {1'b0, oth_e.depth} - {1'b0, rd_data.depth};
    new_entry.parent = b_addr;
    new_entry.depth  = cur_e.depth + tlal_pkg::DEPTH_W'(1);
    new_entry.jump   = (span_low == span_high) ? oth_e.jump : b_addr;
  end

  assign we      = (cmd.op == tlal_pkg::DP_CLEAR) || (cmd.op == tlal_pkg::DP_ADD_WR);
  assign wr_addr = (cmd.op == tlal_pkg::DP_CLEAR) ? clr_cnt : a_addr;
  assign wr_data = (cmd.op == tlal_pkg::DP_CLEAR) ? entry_t'('0) : new_entry;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data   <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.op == tlal_pkg::DP_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tlal_pkg::DP_ACCEPT: begin
        opcode <= tlal_pkg::opcode_t'(in_opcode);
        node_a <= in_node_a;
        node_b <= in_node_b;
        steps  <= in_steps;
        cur_v  <= clip_node(in_node_a);
        oth_v  <= clip_node(in_node_b);
      end
      tlal_pkg::DP_LA_LOAD: begin
        cur_e  <= rd_data;
        target <= (rd_data.depth > steps) ? rd_data.depth - steps : '0;
      end
      tlal_pkg::DP_LCA_V: begin
        cur_e <= rd_data;
      end
      tlal_pkg::DP_LCA_U: begin
        // keep the deeper node in cur, climb it to the other's depth
        if (cur_e.depth > rd_data.depth) begin
          oth_e  <= rd_data;
          target <= rd_data.depth;
        end else begin
          cur_v  <= oth_v;
          cur_e  <= rd_data;
          oth_v  <= cur_v;
          oth_e  <= cur_e;
          target <= cur_e.depth;
        end
      end
      tlal_pkg::DP_TAKE_CUR: begin
        cur_v <= rd_addr_q;
        cur_e <= rd_data;
      end
      tlal_pkg::DP_TAKE_OTH: begin
        oth_v <= rd_addr_q;
        oth_e <= rd_data;
      end
      tlal_pkg::DP_ADD_P: begin
        cur_e <= rd_data;
      end
      tlal_pkg::DP_ADD_J: begin
        oth_e <= rd_data;
      end
      tlal_pkg::DP_OUT: begin
        result_node <= tlal_pkg::NODE_W'(cur_v);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.opcode        = opcode;
    status.a_ok          = (32'(node_a) < 32'(MAX_NODES));
    status.b_ok          = (32'(node_b) < 32'(MAX_NODES));
    status.a_zero        = (node_a == '0);
    status.b_zero        = (node_b == '0);
    status.rd_depth_zero = (rd_data.depth == '0);
    status.climb_more    = (cur_e.depth > target);
    status.jump_ok       = (rd_data.depth >= target);
    status.same_node     = (cur_v == oth_v);
    status.jumps_differ  = (cur_e.jump != oth_e.jump);
    status.clr_last      = (clr_cnt == AW'(MAX_NODES - 1));
  end

endmodule

// ===== hdl/tlal_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlal_ctrl
// sequencer for table clear, leaf add, level ancestor and lca climbs
// ----------------------------------------------------------------------------
`include "tree_level_ancestor_lca_unit_assert.svh"

module tlal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output tlal_pkg::dp_cmd_t     cmd,
  input  tlal_pkg::dp_status_t  status
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_A_CHK,
    S_A_P,
    S_A_J,
    S_A_JJ,
    S_L_LOAD,
    S_Q_V,
    S_Q_U,
    S_CLIMB,
    S_C_J,
    S_C_P,
    S_MERGE,
    S_M_V,
    S_M_U,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   use_jump;
  logic   use_jump_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   load_out;

  assign in_tready  = (state == S_IDLE);
  assign out_tvalid = out_valid;

  always_comb begin
    state_next    = state;
    use_jump_next = use_jump;
    load_out      = 1'b0;
    cmd.op        = tlal_pkg::DP_IDLE;
    cmd.rd_sel    = tlal_pkg::RD_A;
    unique case (state)
      S_CLEAR: begin
        cmd.op = tlal_pkg::DP_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op     = tlal_pkg::DP_ACCEPT;
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (status.opcode)
          tlal_pkg::OP_ADD: begin
            if (status.a_ok && status.b_ok && !status.a_zero) begin
              state_next = S_A_CHK;
            end else begin
              state_next = S_IDLE;
            end
          end
          tlal_pkg::OP_LA:  state_next = S_L_LOAD;
          tlal_pkg::OP_LCA: state_next = S_Q_V;
          default:          state_next = S_IDLE;
        endcase
      end
      S_A_CHK: begin
        // leaf must not be in the tree yet
        if (status.rd_depth_zero) begin
          cmd.rd_sel = tlal_pkg::RD_B;
          state_next = S_A_P;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_A_P: begin
        cmd.op     = tlal_pkg::DP_ADD_P;
        cmd.rd_sel = tlal_pkg::RD_DATA_JUMP;
        if (!status.b_zero && status.rd_depth_zero) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_A_J;
        end
      end
      S_A_J: begin
        cmd.op     = tlal_pkg::DP_ADD_J;
        cmd.rd_sel = tlal_pkg::RD_DATA_JUMP;
        state_next = S_A_JJ;
      end
      S_A_JJ: begin
        cmd.op     = tlal_pkg::DP_ADD_WR;
        state_next = S_IDLE;
      end
      S_L_LOAD: begin
        cmd.op     = tlal_pkg::DP_LA_LOAD;
        state_next = S_CLIMB;
      end
      S_Q_V: begin
        cmd.op     = tlal_pkg::DP_LCA_V;
        cmd.rd_sel = tlal_pkg::RD_B;
        state_next = S_Q_U;
      end
      S_Q_U: begin
        cmd.op     = tlal_pkg::DP_LCA_U;
        state_next = S_CLIMB;
      end
      S_CLIMB: begin
        if (status.climb_more) begin
          cmd.rd_sel = tlal_pkg::RD_CUR_JUMP;
          state_next = S_C_J;
        end else if (status.opcode == tlal_pkg::OP_LCA) begin
          state_next = S_MERGE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_C_J: begin
        // take the jump unless it overshoots the target depth
        if (status.jump_ok) begin
          cmd.op     = tlal_pkg::DP_TAKE_CUR;
          state_next = S_CLIMB;
        end else begin
          cmd.rd_sel = tlal_pkg::RD_CUR_PARENT;
          state_next = S_C_P;
        end
      end
      S_C_P: begin
        cmd.op     = tlal_pkg::DP_TAKE_CUR;
        state_next = S_CLIMB;
      end
      S_MERGE: begin
        if (status.same_node) begin
          state_next = S_OUT;
        end else begin
          use_jump_next = status.jumps_differ;
          cmd.rd_sel    = status.jumps_differ ? tlal_pkg::RD_CUR_JUMP
                                              : tlal_pkg::RD_CUR_PARENT;
          state_next    = S_M_V;
        end
      end
      S_M_V: begin
        cmd.op     = tlal_pkg::DP_TAKE_CUR;
        cmd.rd_sel = use_jump ? tlal_pkg::RD_OTH_JUMP : tlal_pkg::RD_OTH_PARENT;
        state_next = S_M_U;
      end
      S_M_U: begin
        cmd.op     = tlal_pkg::DP_TAKE_OTH;
        state_next = S_MERGE;
      end
      S_OUT: begin
        if (!out_valid || out_tready) begin
          cmd.op     = tlal_pkg::DP_OUT;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      use_jump  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      use_jump  <= use_jump_next;
    end
  end

  `TLAL_ASSERT_SAME(a_clear_blocks_input, clk, rst, state == S_CLEAR, !in_tready, "item taken during table clear")
  `TLAL_ASSERT_NEXT(a_load_sets_valid, clk, rst, load_out, out_valid, "loaded result not presented")
  `TLAL_ASSERT_SAME(a_no_overwrite, clk, rst, load_out && out_valid, out_tready, "result overwritten before taken")
  `TLAL_ASSERT_NEXT(a_accept_starts, clk, rst, in_tvalid && in_tready, state == S_START, "accepted item not started")

endmodule

// ===== hdl/tree_level_ancestor_lca_unit.sv =====
// ----------------------------------------------------------------------------
// tree_level_ancestor_lca_unit
// rooted tree store with level ancestor and lowest common ancestor queries
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command item: tuser is the opcode (0 add leaf,
//   1 level ancestor, 2 lca), tdata holds node_a, node_b and steps.
//   m_axis returns one result_node item for each query; an add gives none.
// timing:
//   one item at a time; a query climbs by jump or parent steps, each step
//   reading the table memory. with skew-binary jumps a climb needs about
//   2*log2(MAX_NODES) steps.
// reset:
//   rst clears the tables by a pass over all MAX_NODES entries, one per
//   cycle; s_axis_tready stays low until the pass is done.
// stalls:
//   a finished result waits in the output register; the next item is
//   accepted meanwhile and runs until its own result is ready to load.
// ----------------------------------------------------------------------------
module tree_level_ancestor_lca_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // node_a[9:0], node_b[19:10], steps[29:20], zero pad
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // result_node[9:0], zero pad
);

  tlal_pkg::dp_cmd_t              cmd;
  tlal_pkg::dp_status_t           status;
  logic [tlal_pkg::NODE_W-1:0]    result_node;

  tlal_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .cmd        (cmd),
    .status     (status)
  );

  tlal_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_opcode   (s_axis_tuser),
    .in_node_a   (s_axis_tdata[9:0]),
    .in_node_b   (s_axis_tdata[19:10]),
    .in_steps    (s_axis_tdata[29:20]),
    .result_node (result_node)
  );

  assign m_axis_tdata = {6'd0, result_node};

endmodule

// ===== tb/sv/tree_level_ancestor_lca_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tree_level_ancestor_lca_unit_tb
// grows random trees of jump-pointer nodes and checks ancestor and lca answers
// against a shadow copy of the parent, depth and jump tables kept in the bench
// ----------------------------------------------------------------------------
module tree_level_ancestor_lca_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_SIZE     = 1024;
  localparam int RANDOM_CMDS   = 1425;
  localparam int DRAIN_EVERY   = 250;
  localparam int WATCHDOG_MAX  = 6000;
  localparam int TAIL_CYCLES   = 200;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    tlal_pkg::opcode_t op;
    logic [9:0]        node_a;
    logic [9:0]        node_b;
    logic [9:0]        steps;
    bit                drain;
  } tree_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // node_a[9:0], node_b[19:10], steps[29:20], zero pad
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // result_node[9:0], zero pad

  tree_level_ancestor_lca_unit #(.MAX_NODES(TREE_SIZE)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow tree, updated as items are accepted
  logic [9:0] tree_parent [TREE_SIZE] = '{default: '0};
  logic [9:0] tree_depth  [TREE_SIZE] = '{default: '0};
  logic [9:0] tree_jump   [TREE_SIZE] = '{default: '0};
  logic [9:0] answers_due [$];

  // generation-time view of the tree, used only to shape the stimulus
  bit         gen_present [TREE_SIZE] = '{0: 1'b1, default: 1'b0};
  int         gen_level   [TREE_SIZE] = '{default: 0};
  logic [9:0] members [$];
  logic [9:0] last_leaf = '0;

  tree_cmd_t  pending_cmds [$];
  tree_cmd_t  active_cmd;
  bit         holding = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         err_count = 0;
  int         idle_cycles = 0;
  int unsigned cyc = 0;
  bit         calm;

  assign calm = (cyc[11:10] == 2'b11);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [9:0] climb_until(logic [9:0] v, logic [9:0] target);
    logic [9:0] j;
    while (tree_depth[v] > target) begin
      j = tree_jump[v];
      if (tree_depth[j] >= target) v = j;
      else v = tree_parent[v];
    end
    return v;
  endfunction

  function automatic logic [9:0] ancestor_at(logic [9:0] v, logic [9:0] k);
    logic [9:0] h;
    h = (tree_depth[v] > k) ? tree_depth[v] - k : 10'd0;
    return climb_until(v, h);
  endfunction

  function automatic logic [9:0] meet_point(logic [9:0] v, logic [9:0] u);
    if (tree_depth[v] > tree_depth[u]) v = climb_until(v, tree_depth[u]);
    else u = climb_until(u, tree_depth[v]);
    while (v != u) begin
      if (tree_jump[v] != tree_jump[u]) begin
        v = tree_jump[v];
        u = tree_jump[u];
      end else begin
        v = tree_parent[v];
        u = tree_parent[u];
      end
    end
    return v;
  endfunction

  function automatic void graft_leaf(logic [9:0] v, logic [9:0] p);
    logic [9:0] jp, jjp;
    int span_low, span_high;
    if (v == 0 || tree_depth[v] != 0) return;
    if (p != 0 && tree_depth[p] == 0) return;
    tree_parent[v] = p;
    tree_depth[v]  = tree_depth[p] + 10'd1;
    jp  = tree_jump[p];
    jjp = tree_jump[jp];
    span_low  = int'(tree_depth[p]) - int'(tree_depth[jp]);
    span_high = int'(tree_depth[jp]) - int'(tree_depth[jjp]);
    tree_jump[v] = (span_low == span_high) ? jjp : p;
  endfunction

  function automatic void apply_cmd(tree_cmd_t c);
    case (c.op)
      tlal_pkg::OP_ADD: graft_leaf(c.node_a, c.node_b);
      tlal_pkg::OP_LA:  answers_due.push_back(ancestor_at(c.node_a, c.steps));
      tlal_pkg::OP_LCA: answers_due.push_back(meet_point(c.node_a, c.node_b));
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(tlal_pkg::opcode_t op, logic [9:0] a, logic [9:0] b,
                                    logic [9:0] k, bit drain);
    tree_cmd_t c;
    c.op = op;
    c.node_a = a;
    c.node_b = b;
    c.steps = k;
    c.drain = drain;
    pending_cmds.push_back(c);
    if (op == tlal_pkg::OP_ADD && a != 0 && !gen_present[a] &&
        (b == 0 || gen_present[b])) begin
      gen_present[a] = 1'b1;
      gen_level[a] = gen_level[b] + 1;
      members.push_back(a);
      last_leaf = a;
    end
  endfunction

  function automatic logic [9:0] pick_member();
    return members[$urandom_range(0, members.size() - 1)];
  endfunction

  function automatic logic [9:0] fresh_node();
    logic [9:0] v;
    do v = 10'($urandom_range(1, TREE_SIZE - 1)); while (gen_present[v]);
    return v;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void build_stimulus();
    int r;
    bit drain;
    logic [9:0] a, b, k;
    members.push_back(10'd0);
    // empty tree, then a short chain with a side branch and the top node index
    queue_cmd(tlal_pkg::OP_LA,  10'd0, 10'd0, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd0, 10'd0, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd1, 10'd0, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd2, 10'd1, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd3, 10'd2, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd4, 10'd3, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd5, 10'd1, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd1023, 10'd4, 10'd0, 1'b0);
    // adds that must leave the tree alone: root, existing node, absent parent
    queue_cmd(tlal_pkg::OP_ADD, 10'd0, 10'd1, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd3, 10'd0, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd6, 10'd700, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_NOP, 10'h3ff, 10'h3ff, 10'h3ff, 1'b0);
    queue_cmd(tlal_pkg::OP_LA,  10'd1023, 10'd0, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LA,  10'd1023, 10'h3ff, 10'h3ff, 1'b0);
    queue_cmd(tlal_pkg::OP_LA,  10'd1023, 10'd0, 10'd2, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd1023, 10'd5, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd5, 10'd1023, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd1023, 10'd1023, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd4, 10'd0, 10'd0, 1'b0);
    // nodes never added behave as depth-zero children of the root
    queue_cmd(tlal_pkg::OP_LA,  10'd512, 10'd0, 10'd5, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd512, 10'd3, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LCA, 10'd512, 10'd1022, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_ADD, 10'd682, 10'd1023, 10'd0, 1'b0);
    queue_cmd(tlal_pkg::OP_LA,  10'd682, 10'd0, 10'd3, 1'b0);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      drain = (i % DRAIN_EVERY == DRAIN_EVERY - 1);
      if (r < 7) begin
        queue_cmd(tlal_pkg::opcode_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), drain);
      end else if (r < 11) begin
        case ($urandom_range(0, 2))
          0: queue_cmd(tlal_pkg::OP_ADD, 10'd0, pick_member(),
                       10'($urandom_range(0, 1023)), drain);
          1: queue_cmd(tlal_pkg::OP_ADD, pick_member(), pick_member(),
                       10'($urandom_range(0, 1023)), drain);
          default: begin
            a = fresh_node();
            b = fresh_node();
            queue_cmd(tlal_pkg::OP_ADD, a, b, 10'($urandom_range(0, 1023)), drain);
          end
        endcase
      end else if (r < 44 && members.size() < TREE_SIZE) begin
        a = fresh_node();
        b = $urandom_range(0, 1) ? last_leaf : pick_member();
        queue_cmd(tlal_pkg::OP_ADD, a, b, 10'($urandom_range(0, 1023)), drain);
      end else if (r < 72) begin
        a = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) : pick_member();
        k = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(0, gen_level[a] + 2));
        queue_cmd(tlal_pkg::OP_LA, a, 10'($urandom_range(0, 1023)), k, drain);
      end else begin
        a = pick_member();
        case ($urandom_range(0, 9))
          0:       b = a;
          1:       b = 10'($urandom_range(0, 1023));
          2, 3:    b = last_leaf;
          default: b = pick_member();
        endcase
        queue_cmd(tlal_pkg::OP_LCA, a, b, 10'($urandom_range(0, 1023)), drain);
      end
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      holding = 1'b0;
      gap_left = 0;
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_cmd(active_cmd);
        holding = 1'b0;
        gap_left = pick_pause();
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && answers_due.size() != 0)) begin
          // a drain-marked item holds off until every answer is back
          active_cmd = pending_cmds.pop_front();
          holding = 1'b1;
          s_axis_tdata <= {2'b00, active_cmd.steps, active_cmd.node_b, active_cmd.node_a};
          s_axis_tuser <= active_cmd.op;
        end
      end
      s_axis_tvalid <= holding;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    logic [9:0] want;
    if (rst) begin
      stall_left = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("unexpected result item: result_node %0d", m_axis_tdata[9:0]);
        end else begin
          want = answers_due.pop_front();
          if (m_axis_tdata[9:0] !== want) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
              $display("result_node mismatch: expected %0d, got %0d", want,
                       m_axis_tdata[9:0]);
          end
        end
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(1, 3);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    cyc++;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0 || holding) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && answers_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
